/* src/assert_macros.svh */
// Assertion macros shared by the mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define SJM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked in the following cycle.
`define SJM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/sjm_pkg.sv */
// Types, constants and helpers of the six-axis joystick mixer.
`default_nettype none
package sjm_pkg;
	localparam int RAW_W    = 13;
	localparam int SUM_W    = 21;
	localparam int CNT_W    = 8;
	localparam int NCH      = 8;
	localparam int CH_W     = 3;
	localparam int VAL_W    = 11;
	localparam int AX_W     = 12;
	localparam int TZ_W     = 13;
	localparam int DZ_W     = 9;
	localparam int INV_W    = 6;
	localparam int SCALE    = 512;
	localparam int SCALE_SH = 9;
	localparam int NUM_W    = 24;
	localparam int IDX_W    = 2;
	localparam int CFG_W    = 9;
	localparam int IN_W     = 104;
	localparam int OUT_W    = 80;
	localparam int ADC_FULL_SCALE_DEF = 8192;

	localparam logic [RAW_W-1:0] AVG_MAX = '1;

	// register indexes
	localparam logic [IDX_W-1:0] REG_DEADZONE = 2'd0;
	localparam logic [IDX_W-1:0] REG_INVERT   = 2'd1;
	localparam logic [IDX_W-1:0] REG_MEASURE  = 2'd2;
	localparam logic [IDX_W-1:0] REG_CALIB    = 2'd3;

	// channel order inside a scan
	localparam int CH_AX = 0;
	localparam int CH_AY = 1;
	localparam int CH_BX = 2;
	localparam int CH_BY = 3;
	localparam int CH_CX = 4;
	localparam int CH_CY = 5;
	localparam int CH_DX = 6;
	localparam int CH_DY = 7;

	// axis bits of the invert mask
	localparam int AXI_TX = 0;
	localparam int AXI_TY = 1;
	localparam int AXI_TZ = 2;
	localparam int AXI_RX = 3;
	localparam int AXI_RY = 4;
	localparam int AXI_RZ = 5;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef struct packed {
		logic signed [AX_W-1:0] rot_z;
		logic signed [AX_W-1:0] rot_y;
		logic signed [AX_W-1:0] rot_x;
		logic signed [TZ_W-1:0] trans_z;
		logic signed [AX_W-1:0] trans_y;
		logic signed [AX_W-1:0] trans_x;
	} axes_t;

	// magnitude of a scaled channel value
	function automatic logic [VAL_W-1:0] abs_val(input val_t v);
		abs_val = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
	endfunction

	// zero a channel whose magnitude is under the deadzone
	function automatic val_t dz_filter(input val_t v, input logic [DZ_W-1:0] dz);
		dz_filter = (abs_val(v) < VAL_W'(dz)) ? '0 : v;
	endfunction
endpackage
`default_nettype wire

/* src/sjm_divider.sv */
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
`include "assert_macros.svh"
module sjm_divider #(
	parameter int NUM_W = sjm_pkg::NUM_W,
	parameter int DVS_W = 14
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  busy,
	output logic                  done,
	output logic [NUM_W-1:0]      quotient
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [NUM_W-1:0] quo_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	// one restoring step
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
		end else begin
			// pulse after the last quotient bit
			done_q <= busy_q && !start && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
				rem_q  <= '0;
				dvs_q  <= divisor;
				quo_q  <= dividend;
			end else if (busy_q) begin
				rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
				quo_q <= {quo_q[NUM_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	`SJM_ASSERT_NEXT(a_start_busy, start, busy, "divider did not start")
	`SJM_ASSERT_NEXT(a_done_after_busy, busy && cnt_q == CNT_W'(1), done && !busy,
		"divider did not finish")
	`SJM_ASSERT(a_done_idle, done |-> !busy, "divider done while busy")
endmodule
`default_nettype wire

/* src/sjm_mixer.sv */
// Mixes eight scaled stick channels into six axes.
`default_nettype none
module sjm_mixer (
	input  wire sjm_pkg::val_t [sjm_pkg::NCH-1:0]   v,
	input  wire logic [sjm_pkg::DZ_W-1:0]           dz,
	input  wire logic [sjm_pkg::INV_W-1:0]          inv,
	output sjm_pkg::axes_t                          axes
);
	localparam int AX_W = sjm_pkg::AX_W;
	localparam int TZ_W = sjm_pkg::TZ_W;
	localparam int VAL_W = sjm_pkg::VAL_W;

	logic                   all_x;
	logic                   all_y;
	logic signed [TZ_W-1:0] sum_x;
	logic signed [TZ_W-1:0] sum_y;
	logic signed [TZ_W-1:0] half_y;
	logic signed [AX_W-1:0] tx, ty, rx, ry, rz;
	logic signed [TZ_W-1:0] tz;
	logic [VAL_W-1:0]       dzw;

	assign dzw = VAL_W'(dz);

	// override detection: every stick of a direction past the deadzone
	assign all_x = (sjm_pkg::abs_val(v[sjm_pkg::CH_AX]) > dzw)
		&& (sjm_pkg::abs_val(v[sjm_pkg::CH_BX]) > dzw)
		&& (sjm_pkg::abs_val(v[sjm_pkg::CH_CX]) > dzw)
		&& (sjm_pkg::abs_val(v[sjm_pkg::CH_DX]) > dzw);
	assign all_y = (sjm_pkg::abs_val(v[sjm_pkg::CH_AY]) > dzw)
		&& (sjm_pkg::abs_val(v[sjm_pkg::CH_BY]) > dzw)
		&& (sjm_pkg::abs_val(v[sjm_pkg::CH_CY]) > dzw)
		&& (sjm_pkg::abs_val(v[sjm_pkg::CH_DY]) > dzw);

	assign sum_x = TZ_W'(v[sjm_pkg::CH_AX]) + TZ_W'(v[sjm_pkg::CH_BX])
		+ TZ_W'(v[sjm_pkg::CH_CX]) + TZ_W'(v[sjm_pkg::CH_DX]);
	assign sum_y = TZ_W'(v[sjm_pkg::CH_AY]) + TZ_W'(v[sjm_pkg::CH_BY])
		+ TZ_W'(v[sjm_pkg::CH_CY]) + TZ_W'(v[sjm_pkg::CH_DY]);
	// halve toward zero
	assign half_y = (sum_y + $signed(TZ_W'(sum_y[TZ_W-1]))) >>> 1;

	// raw axes with overrides
	always_comb begin
		tx = all_x ? '0 : AX_W'(v[sjm_pkg::CH_CY]) - AX_W'(v[sjm_pkg::CH_AY]);
		ty = all_x ? '0 : AX_W'(v[sjm_pkg::CH_DY]) - AX_W'(v[sjm_pkg::CH_BY]);
		tz = all_x ? -sum_x : '0;
		rx = all_y ? '0 : AX_W'(v[sjm_pkg::CH_CX]) - AX_W'(v[sjm_pkg::CH_AX]);
		ry = all_y ? '0 : AX_W'(v[sjm_pkg::CH_BX]) - AX_W'(v[sjm_pkg::CH_DX]);
		rz = all_y ? AX_W'(half_y) : '0;
	end

	// per-axis inversion
	always_comb begin
		axes.trans_x = inv[sjm_pkg::AXI_TX] ? -tx : tx;
		axes.trans_y = inv[sjm_pkg::AXI_TY] ? -ty : ty;
		axes.trans_z = inv[sjm_pkg::AXI_TZ] ? -tz : tz;
		axes.rot_x   = inv[sjm_pkg::AXI_RX] ? -rx : rx;
		axes.rot_y   = inv[sjm_pkg::AXI_RY] ? -ry : ry;
		axes.rot_z   = inv[sjm_pkg::AXI_RZ] ? -rz : rz;
	end
endmodule
`default_nettype wire

/* src/six_axis_joystick_mixer_top.sv */
// Top level of the six-axis joystick mixer: accumulator, sequencer, output register.
//
//  channel | direction | handshake          | content
//  s_      | in        | s_tvalid/s_tready  | one scan of eight ADC readings
//  m_      | out       | m_tvalid/m_tready  | six mixed axes
//  cfg_    | in        | cfg_valid/cfg_ready| register writes, always ready
//
// A scan that does not complete an accumulation is only added to the sums.
// A completing scan runs one averaging divide per channel on one shared divider;
// in measure mode each average is followed by its scaling divide, skipped when
// the upper span is not positive, and the six axes are then mixed.
// s_tready is low while that sequence runs; the result register lets the next
// scans be taken while a result waits, except when a new result needs it.
// Reset clears sums, counts, centres and restores register defaults.
`default_nettype none
`include "assert_macros.svh"
module six_axis_joystick_mixer_top #(
	parameter int ADC_FULL_SCALE = sjm_pkg::ADC_FULL_SCALE_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// raw_ax, raw_ay, raw_bx, raw_by, raw_cx, raw_cy, raw_dx, raw_dy
	input  wire logic [sjm_pkg::IN_W-1:0]    s_tdata,
	// operation
	input  wire logic                        s_tuser,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// trans_x, trans_y, trans_z, rot_x, rot_y, rot_z, zero pad
	output logic [sjm_pkg::OUT_W-1:0]        m_tdata,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [sjm_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [sjm_pkg::CFG_W-1:0]   cfg_data
);
	localparam int RAW_W = sjm_pkg::RAW_W;
	localparam int SUM_W = sjm_pkg::SUM_W;
	localparam int CNT_W = sjm_pkg::CNT_W;
	localparam int NCH   = sjm_pkg::NCH;
	localparam int CH_W  = sjm_pkg::CH_W;
	localparam int VAL_W = sjm_pkg::VAL_W;
	localparam int NUM_W = sjm_pkg::NUM_W;
	localparam int FS_W  = $clog2(ADC_FULL_SCALE + 1);
	localparam int DEN_W = (FS_W > RAW_W) ? FS_W : RAW_W;
	localparam int DVS_W = DEN_W + 1;
	localparam int MAG_W = VAL_W - 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_AVG, ST_AVG_WAIT, ST_SCL, ST_SCL_WAIT, ST_MIX
	} state_t;

	state_t state_q;

	logic [sjm_pkg::DZ_W-1:0]  dz_q;
	logic [sjm_pkg::INV_W-1:0] inv_q;
	logic [CNT_W-1:0]          meas_q;
	logic [CNT_W-1:0]          cal_q;

	logic [SUM_W-1:0]  sums_q [NCH];
	logic [RAW_W-1:0]  centre_q [NCH];
	sjm_pkg::val_t [NCH-1:0] v_q;
	logic [CNT_W-1:0]  scan_q;
	logic              mode_q;
	logic [CNT_W-1:0]  n_q;
	logic [CH_W-1:0]   ch_q;
	logic [RAW_W-1:0]  avg_q;
	logic              neg_q;
	logic [sjm_pkg::OUT_W-1:0] out_q;
	logic              out_vld_q;

	// accept-side signals
	logic              accept;
	logic              mode_chg;
	logic [CNT_W-1:0]  n_raw;
	logic [CNT_W-1:0]  n_eff;
	logic [CNT_W-1:0]  scan_nx;
	logic              fin;
	logic [RAW_W-1:0]  raw [NCH];

	// scaling signals
	logic [RAW_W-1:0]         centre;
	logic                     neg;
	logic [RAW_W-1:0]         mag_d;
	logic signed [DEN_W:0]    den_up;
	logic [DEN_W-1:0]         den;
	logic                     span_bad;
	sjm_pkg::val_t            v_sat_special;

	// divider interface
	logic              div_start;
	logic [NUM_W-1:0]  div_num;
	logic [DVS_W-1:0]  div_dvs;
	logic              div_busy;
	logic              div_done;
	logic [NUM_W-1:0]  div_quo;
	logic [RAW_W-1:0]  avg_clamp;
	logic [MAG_W-1:0]  q_sat;
	sjm_pkg::val_t     v_div;

	sjm_pkg::axes_t    axes;
	logic              out_free;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = out_q;
	assign out_free  = !out_vld_q || m_tready;

	// unpack scan
	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			raw[i] = s_tdata[i*RAW_W +: RAW_W];
		end
	end

	// sample count and completion
	assign mode_chg = s_tuser != mode_q;
	assign n_raw    = s_tuser ? cal_q : meas_q;
	assign n_eff    = (n_raw == '0) ? CNT_W'(1) : n_raw;
	assign scan_nx  = (mode_chg ? '0 : scan_q) + 1'b1;
	assign fin      = (scan_nx == '0) || (scan_nx >= n_eff);

	// centring and span selection
	assign centre   = centre_q[ch_q];
	assign neg      = avg_q < centre;
	assign mag_d    = neg ? centre - avg_q : avg_q - centre;
	assign den_up   = (DEN_W+1)'(ADC_FULL_SCALE) - (DEN_W+1)'(centre);
	assign span_bad = !neg && (den_up <= 0);
	assign den      = neg ? DEN_W'(centre) : den_up[DEN_W-1:0];
	assign v_sat_special = (mag_d != '0) ? VAL_W'(sjm_pkg::SCALE) : '0;

	// divider operands per step
	always_comb begin
		div_start = 1'b0;
		div_num   = NUM_W'(sums_q[ch_q]);
		div_dvs   = DVS_W'(n_q);
		if (state_q == ST_AVG) begin
			div_start = 1'b1;
		end else if (state_q == ST_SCL && !span_bad) begin
			div_start = 1'b1;
			div_num   = NUM_W'({mag_d, {(sjm_pkg::SCALE_SH + 1){1'b0}}}) + NUM_W'(den);
			div_dvs   = {den, 1'b0};
		end
	end

	// quotient post-processing
	assign avg_clamp = (div_quo > NUM_W'(sjm_pkg::AVG_MAX)) ? sjm_pkg::AVG_MAX
		: div_quo[RAW_W-1:0];
	assign q_sat = (div_quo > NUM_W'(sjm_pkg::SCALE)) ? MAG_W'(sjm_pkg::SCALE)
		: div_quo[MAG_W-1:0];
	assign v_div = neg_q ? -VAL_W'(q_sat) : VAL_W'(q_sat);

	sjm_divider #(.NUM_W(NUM_W), .DVS_W(DVS_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	sjm_mixer u_mix (
		.v    (v_q),
		.dz   (dz_q),
		.inv  (inv_q),
		.axes (axes)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q   <= sjm_pkg::DZ_W'(5);
			inv_q  <= sjm_pkg::INV_W'(44);
			meas_q <= CNT_W'(10);
			cal_q  <= CNT_W'(100);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sjm_pkg::REG_DEADZONE: dz_q   <= cfg_data;
				sjm_pkg::REG_INVERT:   inv_q  <= cfg_data[sjm_pkg::INV_W-1:0];
				sjm_pkg::REG_MEASURE:  meas_q <= cfg_data[CNT_W-1:0];
				sjm_pkg::REG_CALIB:    cal_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer with accumulators, centres and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			scan_q    <= '0;
			mode_q    <= 1'b0;
			n_q       <= '0;
			ch_q      <= '0;
			avg_q     <= '0;
			neg_q     <= 1'b0;
			out_q     <= '0;
			out_vld_q <= 1'b0;
			v_q       <= '0;
			for (int i = 0; i < NCH; i++) begin
				sums_q[i]   <= '0;
				centre_q[i] <= '0;
			end
		end else begin
			// result taken; a new one is loaded in ST_MIX instead
			if (m_tready && state_q != ST_MIX) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q <= s_tuser;
						scan_q <= fin ? '0 : scan_nx;
						n_q    <= n_eff;
						ch_q   <= '0;
						for (int i = 0; i < NCH; i++) begin
							sums_q[i] <= (mode_chg ? '0 : sums_q[i]) + SUM_W'(raw[i]);
						end
						if (fin) begin
							state_q <= ST_AVG;
						end
					end
				end
				ST_AVG: begin
					state_q <= ST_AVG_WAIT;
				end
				ST_AVG_WAIT: begin
					if (div_done) begin
						if (mode_q) begin
							centre_q[ch_q] <= avg_clamp;
							ch_q <= ch_q + 1'b1;
							if (ch_q == CH_W'(NCH - 1)) begin
								for (int i = 0; i < NCH; i++) begin
									sums_q[i] <= '0;
								end
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_AVG;
							end
						end else begin
							avg_q   <= avg_clamp;
							state_q <= ST_SCL;
						end
					end
				end
				ST_SCL: begin
					neg_q <= neg;
					if (span_bad) begin
						v_q[ch_q] <= sjm_pkg::dz_filter(v_sat_special, dz_q);
						ch_q <= ch_q + 1'b1;
						state_q <= (ch_q == CH_W'(NCH - 1)) ? ST_MIX : ST_AVG;
					end else begin
						state_q <= ST_SCL_WAIT;
					end
				end
				ST_SCL_WAIT: begin
					if (div_done) begin
						v_q[ch_q] <= sjm_pkg::dz_filter(v_div, dz_q);
						ch_q <= ch_q + 1'b1;
						state_q <= (ch_q == CH_W'(NCH - 1)) ? ST_MIX : ST_AVG;
					end
				end
				ST_MIX: begin
					if (out_free) begin
						out_q <= sjm_pkg::OUT_W'({axes.rot_z, axes.rot_y, axes.rot_x,
							axes.trans_z, axes.trans_y, axes.trans_x});
						out_vld_q <= 1'b1;
						for (int i = 0; i < NCH; i++) begin
							sums_q[i] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SJM_ASSERT(a_start_idle, div_start |-> !div_busy, "divider started while busy")
	`SJM_ASSERT_NEXT(a_mix_load, state_q == ST_MIX && out_free, m_tvalid,
		"result not loaded")
	`SJM_ASSERT_NEXT(a_fin_busy, accept && fin, !s_tready,
		"completing scan did not block input")
endmodule
`default_nettype wire

/* tb/sv/tb_six_axis_joystick_mixer_top.sv */
// Self-checking testbench of the six-axis joystick mixer: scoreboard, stimulus, watchdog.
`timescale 1ns / 1ps
`default_nettype none

// Mixer predictor and queue of expected axis sets.
class mixer_scoreboard;
	logic [8:0] deadzone;
	logic [5:0] invert_mask;
	logic [7:0] measure_n;
	logic [7:0] calib_n;
	logic [20:0] sums[8];
	logic [7:0] scan_cnt;
	logic mode;
	logic [12:0] centres[8];
	sjm_pkg::axes_t expected_axes[$];
	int errors;

	function new();
		deadzone = 9'd5;
		invert_mask = 6'd44;
		measure_n = 8'd10;
		calib_n = 8'd100;
		foreach (sums[i]) sums[i] = '0;
		foreach (centres[i]) centres[i] = '0;
		scan_cnt = '0;
		mode = 1'b0;
		errors = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [8:0] val);
		case (idx)
			sjm_pkg::REG_DEADZONE: deadzone = val;
			sjm_pkg::REG_INVERT: invert_mask = val[5:0];
			sjm_pkg::REG_MEASURE: measure_n = val[7:0];
			sjm_pkg::REG_CALIB: calib_n = val[7:0];
			default: ;
		endcase
	endfunction

	// centred and scaled value of one channel, rounded half away from zero
	function int scale_reading(int avg, int centre);
		int d;
		int den;
		longint q;
		d = avg - centre;
		if (d < 0) den = centre;
		else begin
			den = 8192 - centre;
			if (den <= 0) return (d > 0) ? 512 : 0;
		end
		q = (2 * longint'(d < 0 ? -d : d) * 512 + den) / (2 * longint'(den));
		if (q > 512) q = 512;
		return (d < 0) ? -int'(q) : int'(q);
	endfunction

	function int iabs(int v);
		return (v < 0) ? -v : v;
	endfunction

	// note one accepted scan
	function void note_scan(logic op, logic [103:0] data);
		int n;
		int avg[8];
		int v[8];
		int ax[6];
		int dz;
		bit all_x, all_y;
		sjm_pkg::axes_t r;
		dz = deadzone;
		if (op != mode) begin
			foreach (sums[i]) sums[i] = '0;
			scan_cnt = '0;
			mode = op;
		end
		for (int i = 0; i < 8; i++) sums[i] = sums[i] + 21'(data[i*13 +: 13]);
		n = op ? calib_n : measure_n;
		if (n == 0) n = 1;
		scan_cnt = scan_cnt + 8'd1;
		if (scan_cnt != 0 && scan_cnt < n) return;
		for (int i = 0; i < 8; i++) begin
			avg[i] = int'(sums[i]) / n;
			if (avg[i] > 8191) avg[i] = 8191;
			sums[i] = '0;
		end
		scan_cnt = '0;
		if (op) begin
			for (int i = 0; i < 8; i++) centres[i] = 13'(avg[i]);
			return;
		end
		for (int i = 0; i < 8; i++) begin
			v[i] = scale_reading(avg[i], centres[i]);
			if (iabs(v[i]) < dz) v[i] = 0;
		end
		ax[0] = v[sjm_pkg::CH_CY] - v[sjm_pkg::CH_AY];
		ax[1] = v[sjm_pkg::CH_DY] - v[sjm_pkg::CH_BY];
		ax[3] = v[sjm_pkg::CH_CX] - v[sjm_pkg::CH_AX];
		ax[4] = v[sjm_pkg::CH_BX] - v[sjm_pkg::CH_DX];
		all_x = iabs(v[0]) > dz && iabs(v[2]) > dz && iabs(v[4]) > dz && iabs(v[6]) > dz;
		all_y = iabs(v[1]) > dz && iabs(v[3]) > dz && iabs(v[5]) > dz && iabs(v[7]) > dz;
		// zoom override
		if (all_x) begin
			ax[2] = -(v[0] + v[2] + v[4] + v[6]);
			ax[0] = 0;
			ax[1] = 0;
		end else ax[2] = 0;
		// twist override
		if (all_y) begin
			ax[5] = (v[1] + v[3] + v[5] + v[7]) / 2;
			ax[3] = 0;
			ax[4] = 0;
		end else ax[5] = 0;
		for (int i = 0; i < 6; i++) if (invert_mask[i]) ax[i] = -ax[i];
		r.trans_x = 12'(ax[0]);
		r.trans_y = 12'(ax[1]);
		r.trans_z = 13'(ax[2]);
		r.rot_x = 12'(ax[3]);
		r.rot_y = 12'(ax[4]);
		r.rot_z = 12'(ax[5]);
		expected_axes.push_back(r);
	endfunction

	// compare one output beat with the oldest expectation
	function void check_axes(logic [79:0] data);
		sjm_pkg::axes_t got, want;
		got = data[72:0];
		if (expected_axes.size() == 0) begin
			$error("unexpected output beat %h", data);
			errors++;
			return;
		end
		want = expected_axes.pop_front();
		if (got.trans_x !== want.trans_x) begin
			$error("trans_x expected %0d actual %0d", want.trans_x, got.trans_x); errors++;
		end
		if (got.trans_y !== want.trans_y) begin
			$error("trans_y expected %0d actual %0d", want.trans_y, got.trans_y); errors++;
		end
		if (got.trans_z !== want.trans_z) begin
			$error("trans_z expected %0d actual %0d", want.trans_z, got.trans_z); errors++;
		end
		if (got.rot_x !== want.rot_x) begin
			$error("rot_x expected %0d actual %0d", want.rot_x, got.rot_x); errors++;
		end
		if (got.rot_y !== want.rot_y) begin
			$error("rot_y expected %0d actual %0d", want.rot_y, got.rot_y); errors++;
		end
		if (got.rot_z !== want.rot_z) begin
			$error("rot_z expected %0d actual %0d", want.rot_z, got.rot_z); errors++;
		end
		if (data[79:73] !== 7'd0) begin
			$error("pad expected 0 actual %h", data[79:73]); errors++;
		end
	endfunction
endclass

module tb_six_axis_joystick_mixer_top;
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [sjm_pkg::IN_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [sjm_pkg::OUT_W-1:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [sjm_pkg::IDX_W-1:0] cfg_index;
	logic [sjm_pkg::CFG_W-1:0] cfg_data;

	mixer_scoreboard sb;
	bit hold_output;
	int idle_cycles;

	six_axis_joystick_mixer_top dut (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog: cycles with no beat on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("six_axis_joystick_mixer_top verification failed");
			$finish;
		end
	end

	// note every accepted scan
	always @(posedge clk)
		if (arst_n && s_tvalid && s_tready) sb.note_scan(s_tuser, s_tdata);

	// output side: random stalls, or a long hold-off on request
	initial begin
		int w;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_output) m_tready <= 1'b0;
			else begin
				w = $urandom_range(0, 5);
				if ($urandom_range(0, 3) == 0) w = 0;
				m_tready <= (w == 0);
			end
			if (m_tvalid && m_tready) sb.check_axes(m_tdata);
		end
	end

	// valid stays high after the beat until the next gap, write or drain
	task automatic send_scan(logic op, logic [103:0] data, bit gaps);
		int w;
		w = gaps ? $urandom_range(0, 5) : 0;
		cfg_valid <= 1'b0;
		if (w > 0) begin
			s_tvalid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [8:0] val);
		s_tvalid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	// wait until every result is out plus the longest scan sequence
	task automatic drain();
		s_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		while (sb.expected_axes.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	function automatic logic [103:0] scan_all(logic [12:0] r);
		logic [103:0] d;
		for (int i = 0; i < 8; i++) d[i*13 +: 13] = r;
		return d;
	endfunction

	function automatic logic [103:0] scan_rand();
		logic [103:0] d;
		for (int i = 0; i < 8; i++) begin
			case ($urandom_range(0, 5))
				0: d[i*13 +: 13] = 13'h0000;
				1: d[i*13 +: 13] = 13'h1FFF;
				2: d[i*13 +: 13] = 13'(4096 + $urandom_range(0, 200) - 100);
				default: d[i*13 +: 13] = 13'($urandom);
			endcase
		end
		return d;
	endfunction

	// random scans, each a calibration scan with a chance of calib_pct percent
	task automatic run_phase(int scans, int calib_pct, bit gaps);
		logic op;
		for (int k = 0; k < scans; k++) begin
			op = ($urandom_range(0, 99) < calib_pct);
			send_scan(op, scan_rand(), gaps);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_output = 1'b0;
		idle_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: uncalibrated extremes at reset defaults
		for (int k = 0; k < 10; k++) send_scan(1'b0, scan_all(13'h1FFF), 1'b0);
		drain();
		write_cfg(sjm_pkg::REG_MEASURE, 9'd1);
		write_cfg(sjm_pkg::REG_CALIB, 9'd1);
		write_cfg(sjm_pkg::REG_DEADZONE, 9'd0);
		write_cfg(sjm_pkg::REG_INVERT, 9'd0);
		send_scan(1'b0, scan_all(13'h0000), 1'b0);
		send_scan(1'b0, scan_all(13'd1234), 1'b0);
		// calibrate at full scale: smallest upper span
		send_scan(1'b1, scan_all(13'h1FFF), 1'b0);
		send_scan(1'b0, scan_all(13'h1FFF), 1'b0);
		send_scan(1'b0, scan_all(13'h0000), 1'b0);
		// calibrate mid, then mixed sticks
		send_scan(1'b1, scan_all(13'd4096), 1'b0);
		send_scan(1'b0, {13'd8191, 13'd0, 13'd6000, 13'd2000, 13'd4100, 13'd4090,
			13'd8191, 13'd0}, 1'b0);
		send_scan(1'b0, scan_all(13'd4097), 1'b0);
		drain();
		// zero measure count acts as one; invert all; max deadzone
		write_cfg(sjm_pkg::REG_MEASURE, 9'd0);
		write_cfg(sjm_pkg::REG_INVERT, 9'd63);
		write_cfg(sjm_pkg::REG_DEADZONE, 9'd511);
		send_scan(1'b0, scan_all(13'h1FFF), 1'b0);
		send_scan(1'b0, scan_all(13'h0000), 1'b0);
		drain();
		// count already reached: lower register mid accumulation
		write_cfg(sjm_pkg::REG_MEASURE, 9'd255);
		write_cfg(sjm_pkg::REG_DEADZONE, 9'd3);
		for (int k = 0; k < 4; k++) send_scan(1'b0, scan_all(13'd7000), 1'b0);
		write_cfg(sjm_pkg::REG_MEASURE, 9'd2);
		send_scan(1'b0, scan_all(13'd100), 1'b0);
		drain();

		// random phases over several settings
		for (int p = 0; p < 12; p++) begin
			write_cfg(sjm_pkg::REG_DEADZONE, (p == 3) ? 9'd511 : 9'($urandom_range(0, 40)));
			write_cfg(sjm_pkg::REG_INVERT, 9'($urandom_range(0, 63)));
			write_cfg(sjm_pkg::REG_MEASURE, (p == 5) ? 9'd0 : 9'($urandom_range(1, 4)));
			write_cfg(sjm_pkg::REG_CALIB, (p == 7) ? 9'd255 : 9'($urandom_range(1, 3)));
			if (p == 2) begin
				// long receiver hold-off while scans keep coming
				hold_output = 1'b1;
				fork
					begin
						repeat (3000) @(posedge clk);
						hold_output = 1'b0;
					end
					run_phase(60, 5, 1'b0);
				join
			end else
				run_phase(140, (p == 7) ? 2 : 15, (p % 3) != 1);
			drain();
		end
		// long count extreme, one pass
		write_cfg(sjm_pkg::REG_MEASURE, 9'd255);
		for (int k = 0; k < 255; k++) send_scan(1'b0, scan_rand(), 1'b0);
		drain();

		if (sb.errors == 0 && sb.expected_axes.size() == 0)
			$display("six_axis_joystick_mixer_top verification clean");
		else
			$display("six_axis_joystick_mixer_top verification failed");
		$finish;
	end
endmodule

`default_nettype wire
